// File: hdl/assert_macros.svh
// Assertion macros for the RTL files of the MD5 digest block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/md5_pkg.sv
// Types, constants and round functions of the MD5 digest block.
// Depends on nothing; used by md5_message_digest, md5_digest_checker and the testbench.
`default_nettype none

package md5_pkg;

    localparam int unsigned BlockWords = 16;
    localparam int unsigned WordWidth  = 32;
    localparam int unsigned LenWidth   = 61;

    localparam logic [31:0] Iv0 = 32'h67452301;
    localparam logic [31:0] Iv1 = 32'hEFCDAB89;
    localparam logic [31:0] Iv2 = 32'h98BADCFE;
    localparam logic [31:0] Iv3 = 32'h10325476;
    localparam logic [31:0] PadWord = 32'h00000080;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  bytes_valid;
        logic        last;
    } t_md5_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_number;
        logic        digest_done;
    } t_md5_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } t_md5_state;

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index of a round: bits 5:4 pick the formula, bits 3:0 feed it.
    function automatic logic [3:0] md5_g(input logic [5:0] idx);
        logic [3:0] r;
        logic [3:0] g;
        r = idx[3:0];
        case (idx[5:4])
            2'd0:    g = r;
            2'd1:    g = 4'((r << 2) + r + 4'd1);
            2'd2:    g = 4'((r << 1) + r + 4'd5);
            default: g = 4'((r << 3) - r);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

endpackage

`default_nettype wire

// File: hdl/md5_message_digest.sv
// Top level of the MD5 digest block: input packing, padding, round engine and output.
// Depends on md5_pkg, md5_ram and assert_macros.svh.
//
// Streams a message in as little-endian 32-bit words and returns the four MD5 digest
// words after the last word. The sixteenth word of a block starts the compression,
// which runs one round per cycle against the block memory: it primes the memory read,
// runs the rounds and adds the result into the chaining value. After the last word the
// padding and length words are written one a cycle and one or two more compressions
// follow; the four digest words then leave one per transfer, after which the block
// takes the next message. No input is taken while a block is compressed, padded or
// the digest is delivered.
`default_nettype none

module md5_message_digest (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire md5_pkg::t_md5_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output md5_pkg::t_md5_out      o_out_data
);

    import md5_pkg::*;
    `include "assert_macros.svh"

    t_md5_state           r_state, n_state;
    logic [31:0]          r_chain [4];
    logic [31:0]          n_chain [4];
    logic [31:0]          r_a, r_b, r_c, r_d;
    logic [31:0]          n_a, n_b, n_c, n_d;
    logic [3:0]           r_fill, n_fill;
    logic [LenWidth-1:0]  r_len, n_len;
    logic [5:0]           r_rnd, n_rnd;
    logic [1:0]           r_oidx, n_oidx;
    logic                 r_fin, n_fin;
    logic                 r_need80, n_need80;
    logic                 r_len_lo, n_len_lo;
    logic                 r_msg_done, n_msg_done;

    logic                 in_xfer, out_xfer;
    logic                 we;
    logic [31:0]          wdata;
    logic [3:0]           raddr;
    logic [31:0]          rdata;
    logic [2:0]           vsat;
    logic [31:0]          last_word;
    logic [31:0]          f, t, rot;

    md5_ram #(
        .WIDTH (WordWidth),
        .DEPTH (BlockWords)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_fill),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;

    always_comb begin
        o_out_data.digest_word = r_chain[r_oidx];
        o_out_data.word_number = r_oidx;
        o_out_data.digest_done = (r_oidx == 2'd3);
    end

    always_comb begin
        vsat = (i_in_data.bytes_valid > 3'd4) ? 3'd4 : i_in_data.bytes_valid;
        case (vsat)
            3'd0:    last_word = PadWord;
            3'd1:    last_word = {16'h0, PadWord[7:0], i_in_data.data_word[7:0]};
            3'd2:    last_word = {8'h0, PadWord[7:0], i_in_data.data_word[15:0]};
            3'd3:    last_word = {PadWord[7:0], i_in_data.data_word[23:0]};
            default: last_word = i_in_data.data_word;
        endcase
    end

    always_comb begin
        case (r_rnd[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        t   = r_a + f + md5_k(r_rnd) + rdata;
        rot = md5_rotl(t, md5_s(r_rnd));
    end

    always_comb begin
        n_state    = r_state;
        n_chain    = r_chain;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_d        = r_d;
        n_fill     = r_fill;
        n_len      = r_len;
        n_rnd      = r_rnd;
        n_oidx     = r_oidx;
        n_fin      = r_fin;
        n_need80   = r_need80;
        n_len_lo   = r_len_lo;
        n_msg_done = r_msg_done;
        we         = 1'b0;
        wdata      = '0;
        raddr      = md5_g(6'(r_rnd + 6'd1));

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    we     = 1'b1;
                    n_fill = r_fill + 4'd1;
                    if (i_in_data.last) begin
                        wdata    = last_word;
                        n_len    = r_len + LenWidth'(vsat);
                        n_fin    = 1'b1;
                        n_need80 = (vsat == 3'd4);
                        n_state  = (r_fill == 4'd15) ? ST_PRIME : ST_PAD;
                    end else begin
                        wdata = i_in_data.data_word;
                        n_len = r_len + LenWidth'(4);
                        if (r_fill == 4'd15) begin
                            n_state = ST_PRIME;
                        end
                    end
                end
            end
            ST_PAD: begin
                we     = 1'b1;
                n_fill = r_fill + 4'd1;
                if (r_need80) begin
                    wdata    = PadWord;
                    n_need80 = 1'b0;
                end else if (r_fill == 4'd14) begin
                    wdata    = {r_len[28:0], 3'b000};
                    n_len_lo = 1'b1;
                end else if (r_fill == 4'd15 && r_len_lo) begin
                    wdata      = r_len[60:29];
                    n_msg_done = 1'b1;
                end else begin
                    wdata = '0;
                end
                if (r_fill == 4'd15) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                raddr   = md5_g(6'd0);
                n_rnd   = 6'd0;
                n_a     = r_chain[0];
                n_b     = r_chain[1];
                n_c     = r_chain[2];
                n_d     = r_chain[3];
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_a   = r_d;
                n_d   = r_c;
                n_c   = r_b;
                n_b   = r_b + rot;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_oidx     = 2'd0;
                if (r_msg_done) begin
                    n_state = ST_OUT;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    n_oidx = r_oidx + 2'd1;
                    if (r_oidx == 2'd3) begin
                        n_chain[0] = Iv0;
                        n_chain[1] = Iv1;
                        n_chain[2] = Iv2;
                        n_chain[3] = Iv3;
                        n_fill     = '0;
                        n_len      = '0;
                        n_fin      = 1'b0;
                        n_need80   = 1'b0;
                        n_len_lo   = 1'b0;
                        n_msg_done = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_chain[0] <= Iv0;
            r_chain[1] <= Iv1;
            r_chain[2] <= Iv2;
            r_chain[3] <= Iv3;
            r_fill     <= '0;
            r_len      <= '0;
            r_rnd      <= '0;
            r_oidx     <= '0;
            r_fin      <= 1'b0;
            r_need80   <= 1'b0;
            r_len_lo   <= 1'b0;
            r_msg_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_chain    <= n_chain;
            r_fill     <= n_fill;
            r_len      <= n_len;
            r_rnd      <= n_rnd;
            r_oidx     <= n_oidx;
            r_fin      <= n_fin;
            r_need80   <= n_need80;
            r_len_lo   <= n_len_lo;
            r_msg_done <= n_msg_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
    end

    `ASSERT_NEXT(a_full_block_compresses, i_clk, i_rst_n,
        in_xfer && !i_in_data.last && r_fill == 4'd15, r_state == ST_PRIME,
        "A sixteenth word did not start a compression.")
    `ASSERT_NEXT(a_rounds_end_in_update, i_clk, i_rst_n,
        r_state == ST_ROUND && r_rnd == 6'd63, r_state == ST_UPDATE,
        "The round engine did not finish after 64 rounds.")
    `ASSERT_SAME(a_digest_on_empty_block, i_clk, i_rst_n,
        r_state == ST_OUT, r_fill == 4'd0 && r_msg_done,
        "Digest delivered before the length words were compressed.")
    `ASSERT_NEXT(a_iv_after_digest, i_clk, i_rst_n,
        out_xfer && o_out_data.digest_done,
        r_state == ST_IDLE && r_chain[0] == Iv0 && r_len == '0,
        "The block did not return to the initial vector after a digest.")

endmodule

`default_nettype wire

// File: hdl/md5_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing; holds the message block of the MD5 digest block.
`default_nettype none

module md5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: bench/md5_digest_checker.sv
// Checker for the MD5 digest block: watches both channels, predicts the digest words
// of every message and compares each output transfer with the oldest prediction.
// Depends on md5_pkg for the transfer types, the initial vector and the pad word.
module md5_digest_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire md5_pkg::t_md5_in  i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire md5_pkg::t_md5_out i_out_data,
    output int                     o_fail_count,
    output int                     o_words_due
);

    logic [31:0] round_add [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int unsigned rot_amount [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                     4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0]       chain [4];
    logic [31:0]       block_buf [16];
    int unsigned       block_fill;
    logic [60:0]       msg_bytes;
    md5_pkg::t_md5_out digest_words_due [$];
    int                fail_total = 0;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void start_message();
        chain[0] = md5_pkg::Iv0;
        chain[1] = md5_pkg::Iv1;
        chain[2] = md5_pkg::Iv2;
        chain[3] = md5_pkg::Iv3;
        block_fill = 0;
        msg_bytes = '0;
    endfunction

    function automatic void md5_compress_block();
        logic [31:0] a, b, c, d, f, t;
        int unsigned g, ph;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++) begin
            ph = r / 16;
            case (ph)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r % 16;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = a + f + round_add[r] + block_buf[g];
            a = d;
            d = c;
            c = b;
            b = b + rotate_left(t, rot_amount[ph * 4 + r % 4]);
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endfunction

    function automatic void md5_absorb_word(input logic [31:0] w);
        block_buf[block_fill] = w;
        block_fill++;
        if (block_fill == 16) begin
            md5_compress_block();
            block_fill = 0;
        end
    endfunction

    function automatic void md5_take_item(input md5_pkg::t_md5_in item);
        int unsigned       n;
        logic [31:0]       keep;
        logic [63:0]       bit_len;
        md5_pkg::t_md5_out word;
        if (!item.last) begin
            msg_bytes = msg_bytes + 61'd4;
            md5_absorb_word(item.data_word);
            return;
        end
        n = (item.bytes_valid > 3'd4) ? 4 : item.bytes_valid;
        msg_bytes = msg_bytes + 61'(n);
        if (n == 4) begin
            md5_absorb_word(item.data_word);
            md5_absorb_word(md5_pkg::PadWord);
        end else begin
            keep = (32'h1 << (8 * n)) - 32'h1;
            md5_absorb_word((item.data_word & keep) | (md5_pkg::PadWord << (8 * n)));
        end
        if (block_fill > 14) begin
            while (block_fill != 0) md5_absorb_word(32'h0);
        end
        while (block_fill < 14) md5_absorb_word(32'h0);
        bit_len = {msg_bytes, 3'b000};
        md5_absorb_word(bit_len[31:0]);
        md5_absorb_word(bit_len[63:32]);
        for (int k = 0; k < 4; k++) begin
            word.digest_word = chain[k];
            word.word_number = 2'(k);
            word.digest_done = (k == 3);
            digest_words_due = {digest_words_due, word};
        end
        start_message();
    endfunction

    initial start_message();

    always @(posedge i_clk) begin
        md5_pkg::t_md5_out want;
        if (!i_rst_n) begin
            start_message();
            digest_words_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                md5_take_item(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (digest_words_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected digest transfer, actual %h", $time, i_out_data);
                end else begin
                    want = digest_words_due.pop_front();
                    if (i_out_data.digest_word !== want.digest_word) begin
                        fail_total++;
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 want.digest_word, i_out_data.digest_word);
                    end
                    if (i_out_data.word_number !== want.word_number) begin
                        fail_total++;
                        $display("%0t: word_number expected %0d actual %0d", $time,
                                 want.word_number, i_out_data.word_number);
                    end
                    if (i_out_data.digest_done !== want.digest_done) begin
                        fail_total++;
                        $display("%0t: digest_done expected %b actual %b", $time,
                                 want.digest_done, i_out_data.digest_done);
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_words_due  <= digest_words_due.size();
    end

endmodule

// File: bench/tb_md5_message_digest.sv
// Testbench top for md5_message_digest: clock, reset, message stimulus with random
// idling on both channels, and the verdict. Depends on md5_pkg and md5_digest_checker.
module tb_md5_message_digest;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              out_stall = 1'b0;
    md5_pkg::t_md5_in  in_data = '0;
    logic              in_stall;
    logic              out_valid;
    md5_pkg::t_md5_out out_data;
    int                fail_count;
    int                words_due;
    bit                idle_on = 1'b1;
    int                items_sent = 0;
    int                messages_sent = 0;

    md5_message_digest u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    md5_digest_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= idle_on && ($urandom_range(99) < 33);
    end

    task automatic send_word(input logic [31:0] data, input logic [2:0] count, input logic fin);
        md5_pkg::t_md5_in item;
        item.data_word   = data;
        item.bytes_valid = count;
        item.last        = fin;
        while (idle_on && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (fin) messages_sent++;
    endtask

    task automatic send_message(input int body, input logic [2:0] tail);
        for (int k = 0; k < body; k++) begin
            send_word($urandom, 3'($urandom_range(7)), 1'b0);
        end
        send_word($urandom, tail, 1'b1);
    endtask

    initial begin
        int body;
        int msg;
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message with junk in the data lanes, then short and oversized counts.
        send_word($urandom, 3'd0, 1'b1);
        send_word(32'h00636261, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'hFFFFFFFF, 3'd5, 1'b1);
        send_word(32'h00000000, 3'd7, 1'b1);
        send_word(32'hFFFFFFFF, 3'd6, 1'b1);
        send_word($urandom | 32'hFFFFFF00, 3'd1, 1'b1);
        // Fifteen words put the pad where the length no longer fits in the block.
        send_message(14, 3'd0);

        msg = 0;
        while (items_sent < 200) begin
            idle_on <= !(msg >= 4 && msg < 8);
            body = ($urandom_range(9) == 0) ? $urandom_range(40, 28) : $urandom_range(17);
            send_message(body, 3'($urandom_range(7)));
            msg++;
        end
        in_valid <= 1'b0;

        waited = 0;
        while (words_due != 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);

        $display("Sent %0d input transfers forming %0d messages, short and multi-block.",
                 items_sent, messages_sent);
        $display("Expected %0d digest words, %0d still outstanding.",
                 4 * messages_sent, words_due);
        if (fail_count == 0 && words_due == 0) begin
            $display("tb_md5_message_digest: PASS");
        end else begin
            $display("tb_md5_message_digest: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out waiting on the digest block.");
        $display("tb_md5_message_digest: FAIL");
        $finish;
    end

endmodule
